### rtl/psmd_pkg.sv
// Shared types, constants and the event classification function of the mouse packet decoder.
package psmd_pkg;

    localparam int unsigned STATUS_W = 8;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned DELTA_W  = 9;
    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 32;

    // Status byte bit positions
    localparam int unsigned STAT_OBF_BIT     = 0;
    localparam int unsigned STAT_AUX_BIT     = 5;
    localparam int unsigned STAT_TIMEOUT_BIT = 6;
    localparam int unsigned STAT_PARITY_BIT  = 7;

    // First packet byte bit positions
    localparam int unsigned PKT_LEFT_BIT   = 0;
    localparam int unsigned PKT_RIGHT_BIT  = 1;
    localparam int unsigned PKT_MIDDLE_BIT = 2;
    localparam int unsigned PKT_SYNC_BIT   = 3;
    localparam int unsigned PKT_XSIGN_BIT  = 4;
    localparam int unsigned PKT_YSIGN_BIT  = 5;
    localparam int unsigned PKT_XOVF_BIT   = 6;
    localparam int unsigned PKT_YOVF_BIT   = 7;

    // Position of the next byte within a packet
    localparam logic [1:0] IDX_FIRST  = 2'd0;
    localparam logic [1:0] IDX_SECOND = 2'd1;
    localparam logic [1:0] IDX_THIRD  = 2'd2;
    localparam logic [1:0] IDX_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        EV_MANY  = 3'd0,
        EV_LDOWN = 3'd1,
        EV_LUP   = 3'd2,
        EV_MDOWN = 3'd3,
        EV_MUP   = 3'd4,
        EV_RDOWN = 3'd5,
        EV_RUP   = 3'd6,
        EV_MOVE  = 3'd7
    } event_kind_t;

    typedef struct packed {
        logic [DATA_W-1:0]   data_byte;
        logic [STATUS_W-1:0] status_byte;
    } item_t;

    typedef struct packed {
        event_kind_t               event_kind;
        logic signed [DELTA_W-1:0] delta_y;
        logic signed [DELTA_W-1:0] delta_x;
        logic                      y_overflow;
        logic                      x_overflow;
        logic                      middle_button;
        logic                      right_button;
        logic                      left_button;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

    // Two or more buttons give many down; otherwise the buttons are checked in the
    // order left, middle, right: a held button gives its down event, and a released
    // button whose down event was the previous event gives its up event.
    function automatic event_kind_t classify(input logic lb, input logic mb,
                                             input logic rb, input event_kind_t prev);
        event_kind_t ev;
        if ((lb && mb) || (lb && rb) || (mb && rb)) begin
            ev = EV_MANY;
        end else if (lb) begin
            ev = EV_LDOWN;
        end else if (prev == EV_LDOWN) begin
            ev = EV_LUP;
        end else if (mb) begin
            ev = EV_MDOWN;
        end else if (prev == EV_MDOWN) begin
            ev = EV_MUP;
        end else if (rb) begin
            ev = EV_RDOWN;
        end else if (prev == EV_RDOWN) begin
            ev = EV_RUP;
        end else begin
            ev = EV_MOVE;
        end
        return ev;
    endfunction

endpackage

### rtl/psmd_in_stage.sv
// Input register stage of the mouse packet decoder.
module psmd_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  psmd_pkg::item_t     s_item,
    input  logic                take,
    output logic                item_valid,
    output psmd_pkg::item_t     item
);
    import psmd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

### rtl/psmd_decode.sv
// Packet assembly, event classification and result register of the mouse packet decoder.
module psmd_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  psmd_pkg::item_t     item,
    output logic                take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output psmd_pkg::result_t   m_result
);
    import psmd_pkg::*;

    logic [1:0]        byte_index_reg, byte_index_next;
    logic [DATA_W-1:0] first_byte_reg, first_byte_next;
    logic [DATA_W-1:0] second_byte_reg, second_byte_next;
    event_kind_t       last_event_reg, last_event_next;
    logic              res_valid_reg, res_valid_next;
    result_t           res_reg;
    result_t           res_calc;
    logic              byte_ok;
    logic              produce;

    assign take = item_valid && (!res_valid_reg || m_tready);

    assign byte_ok = item.status_byte[STAT_AUX_BIT]
                  && !item.status_byte[STAT_PARITY_BIT]
                  && !item.status_byte[STAT_TIMEOUT_BIT]
                  && item.status_byte[STAT_OBF_BIT];

    always_comb begin
        byte_index_next  = byte_index_reg;
        first_byte_next  = first_byte_reg;
        second_byte_next = second_byte_reg;
        last_event_next  = last_event_reg;
        produce          = 1'b0;

        res_calc.left_button   = first_byte_reg[PKT_LEFT_BIT];
        res_calc.right_button  = first_byte_reg[PKT_RIGHT_BIT];
        res_calc.middle_button = first_byte_reg[PKT_MIDDLE_BIT];
        res_calc.x_overflow    = first_byte_reg[PKT_XOVF_BIT];
        res_calc.y_overflow    = first_byte_reg[PKT_YOVF_BIT];
        res_calc.delta_x       = {first_byte_reg[PKT_XSIGN_BIT], second_byte_reg};
        res_calc.delta_y       = {first_byte_reg[PKT_YSIGN_BIT], item.data_byte};
        res_calc.event_kind    = classify(first_byte_reg[PKT_LEFT_BIT],
                                          first_byte_reg[PKT_MIDDLE_BIT],
                                          first_byte_reg[PKT_RIGHT_BIT],
                                          last_event_reg);

        if (take && byte_ok) begin
            case (byte_index_reg)
                IDX_SECOND: begin
                    second_byte_next = item.data_byte;
                    byte_index_next  = IDX_THIRD;
                end
                IDX_THIRD: begin
                    byte_index_next = IDX_FIRST;
                    last_event_next = res_calc.event_kind;
                    produce         = 1'b1;
                end
                default: begin
                    // First byte, or the unused index: resynchronise on the sync bit.
                    if (item.data_byte[PKT_SYNC_BIT]) begin
                        first_byte_next = item.data_byte;
                        byte_index_next = IDX_SECOND;
                    end else begin
                        byte_index_next = IDX_FIRST;
                    end
                end
            endcase
        end

        if (produce) begin
            res_valid_next = 1'b1;
        end else if (m_tready) begin
            res_valid_next = 1'b0;
        end else begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg  <= IDX_FIRST;
            first_byte_reg  <= '0;
            second_byte_reg <= '0;
            last_event_reg  <= EV_MOVE;
            res_valid_reg   <= 1'b0;
        end else begin
            byte_index_reg  <= byte_index_next;
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
            last_event_reg  <= last_event_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            res_reg <= res_calc;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_result = res_reg;

`ifndef SYNTH
    a_index_never_unused: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_index_reg != IDX_UNUSED)
        else $error("byte index reached the unused value");

    a_result_only_on_third: assert property (@(posedge aclk) disable iff (!aresetn)
        produce |-> (byte_index_reg == IDX_THIRD))
        else $error("result produced outside the third packet byte");

    a_last_event_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        produce |=> (last_event_reg == res_reg.event_kind))
        else $error("previous event does not match the emitted event");

    a_many_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && ($countones({res_reg.left_button, res_reg.middle_button,
                                       res_reg.right_button}) >= 2))
        |-> (res_reg.event_kind == EV_MANY))
        else $error("two or more buttons held without a many-down event");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !m_tready) |-> !produce)
        else $error("stalled result overwritten");
`endif

endmodule

### rtl/ps2_mouse_packet_decoder_unit.sv
// Top level of the PS/2 mouse three-byte packet decoder.
// An accepted third byte passes the input register, and its result is held in the result register.
// Throughput: one status and data byte pair per cycle while the result side takes its output.
// The input register and the result register set this figure; each holds one transaction.
// Reset (aresetn low, synchronous) empties both registers, returns the decoder to waiting
// for a first byte and sets the previous event to move.
module ps2_mouse_packet_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] status_byte, [15:8] data_byte
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] left_button, [1] right_button, [2] middle_button, [3] x_overflow,
    // [4] y_overflow, [13:5] delta_x, [22:14] delta_y, [25:23] event_kind, [31:26] zero
    output logic [31:0] m_tdata
);
    import psmd_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    result_t m_result;

    // Input transaction fields, status in the low byte.
    assign s_item.status_byte = s_tdata[STATUS_W-1:0];
    assign s_item.data_byte   = s_tdata[STATUS_W+DATA_W-1:STATUS_W];

    // The input stage holds one accepted transaction; it is released into the decoder
    // whenever the result register is empty or being emptied in the same cycle.
    psmd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // The decoder filters rejected bytes, assembles the packet and classifies the
    // event; a result is registered only on the third byte of a packet.
    psmd_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (m_result)
    );

    // The result struct is packed with the left button in bit zero; pad to whole bytes.
    assign m_tdata = {{(M_TDATA_W-RESULT_W){1'b0}}, m_result};

endmodule
